// ----- rtl/growing_tree_maze_generator_assert.svh -----
// Assertion helpers for the maze generator datapath
`ifndef GROWING_TREE_MAZE_GENERATOR_ASSERT_SVH
`define GROWING_TREE_MAZE_GENERATOR_ASSERT_SVH

// condition holds at every edge outside reset
`define GTM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define GTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define GTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gtm_pkg.sv -----
package gtm_pkg;

	localparam int COORD_W        = 8;
	localparam int XY_OUT_W       = 6;
	localparam int KIND_W         = 2;
	localparam int OPEN_W         = 11;
	localparam int RAND_W         = 16;
	localparam int CFG_IDX_W      = 1;
	localparam int DEF_GRID_W     = 63;
	localparam int DEF_GRID_H     = 63;
	localparam int DEF_LIST_DEPTH = 1024;

	localparam logic [XY_OUT_W-1:0] START_RESET = 6'd30;

	localparam logic [KIND_W-1:0] KIND_WALL     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PASSAGE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FRONTIER = 2'd2;

	localparam logic CMD_RESTART = 1'b0;
	localparam logic CMD_STEP    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_START_X = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 1'd1;

	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLR,
		OP_SEED,
		OP_DIV,
		OP_PICK_RD,
		OP_PICK_LATCH,
		OP_CARVE_RD,
		OP_CARVE1,
		OP_CARVE2,
		OP_NB_FIRST,
		OP_NB,
		OP_NB_LAST,
		OP_REMOVE,
		OP_SH_RD,
		OP_SH_WR,
		OP_DEC,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] sel;
	} gtm_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_last;
		logic count_zero;
		logic carve_ok;
		logic open_left;
		logic shift_more;
		logic emit_last;
	} gtm_stat_t;

	function automatic logic signed [2:0] step_dx(input logic [1:0] dir);
		case (dir)
			DIR_LEFT:  step_dx = -3'sd1;
			DIR_RIGHT: step_dx = 3'sd1;
			default:   step_dx = 3'sd0;
		endcase
	endfunction

	function automatic logic signed [2:0] step_dy(input logic [1:0] dir);
		case (dir)
			DIR_UP:   step_dy = 3'sd1;
			DIR_DOWN: step_dy = -3'sd1;
			default:  step_dy = 3'sd0;
		endcase
	endfunction

endpackage

// ----- rtl/growing_tree_maze_generator.sv -----
// Channel   Handshake                 Payload
// request   start / busy              command, rand_value, direction
// result    strobe (one cycle)        write_valid, cell_x, cell_y, cell_kind, last,
//                                     done_res, open_count
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// After reset the grid memory is swept once, one cell a cycle, with busy high; a restart
// repeats the sweep, then seeds the start point and emits its result. A step on an empty
// list only emits its result; otherwise it runs a bit-serial modulo, list and grid reads,
// a carve when allowed, removal of a point with list entries moved down, and one result per cycle (1 to 3).
// Results leave on strobe and cannot be stalled; cfg_ready is always high.
module growing_tree_maze_generator import gtm_pkg::*; #(
	parameter int GRID_W     = DEF_GRID_W,
	parameter int GRID_H     = DEF_GRID_H,
	parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 command,
	input  logic [RAND_W-1:0]    rand_value,
	input  logic [1:0]           direction,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [XY_OUT_W-1:0]  cfg_data,
	output logic                 strobe,
	output logic                 write_valid,
	output logic [XY_OUT_W-1:0]  cell_x,
	output logic [XY_OUT_W-1:0]  cell_y,
	output logic [KIND_W-1:0]    cell_kind,
	output logic                 last,
	output logic                 done_res,
	output logic [OPEN_W-1:0]    open_count
);

	gtm_cmd_t  cmd;
	gtm_stat_t stat;

	assign cfg_ready = 1'b1;

	gtm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	gtm_datapath #(
		.GRID_W     (GRID_W),
		.GRID_H     (GRID_H),
		.LIST_DEPTH (LIST_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.rand_value  (rand_value),
		.direction   (direction),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.strobe      (strobe),
		.write_valid (write_valid),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cell_kind   (cell_kind),
		.last        (last),
		.done_res    (done_res),
		.open_count  (open_count)
	);

endmodule

// ----- rtl/gtm_datapath.sv -----
`include "growing_tree_maze_generator_assert.svh"

module gtm_datapath import gtm_pkg::*; #(
	parameter int GRID_W     = DEF_GRID_W,
	parameter int GRID_H     = DEF_GRID_H,
	parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gtm_cmd_t             cmd,
	output gtm_stat_t            stat,
	input  logic [RAND_W-1:0]    rand_value,
	input  logic [1:0]           direction,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [XY_OUT_W-1:0]  cfg_data,
	output logic                 strobe,
	output logic                 write_valid,
	output logic [XY_OUT_W-1:0]  cell_x,
	output logic [XY_OUT_W-1:0]  cell_y,
	output logic [KIND_W-1:0]    cell_kind,
	output logic                 last,
	output logic                 done_res,
	output logic [OPEN_W-1:0]    open_count
);

	localparam int GRID_N = GRID_W * GRID_H;
	localparam int AW     = $clog2(GRID_N);
	localparam int LW     = $clog2(LIST_DEPTH);
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int SW     = COORD_W + 2;
	localparam int PW     = 2 * COORD_W;
	localparam int DCW    = $clog2(RAND_W);

	logic [XY_OUT_W-1:0] start_x_q, start_y_q;
	logic [RAND_W-1:0]   dvd_q;
	logic [CNT_W-1:0]    rem_q;
	logic [DCW-1:0]      div_cnt_q;
	logic [1:0]          dir_q;
	logic [COORD_W-1:0]  px_q, py_q;
	logic [CNT_W-1:0]    count_q, ptr_q;
	logic [COORD_W-1:0]  sx_q, sy_q;
	logic                open_left_q;

	logic [KIND_W-1:0] grid_mem [GRID_N];
	logic [KIND_W-1:0] grid_rd_q;
	logic              grid_in_q;
	logic [PW-1:0]     list_mem [LIST_DEPTH];
	logic [PW-1:0]     list_rd_q;

	logic [XY_OUT_W-1:0] slot_x_q [3];
	logic [XY_OUT_W-1:0] slot_y_q [3];
	logic [KIND_W-1:0]   slot_k_q [3];
	logic [1:0]          n_q, k_q;

	logic                strobe_q, write_valid_q, last_q, done_res_q;
	logic [XY_OUT_W-1:0] cell_x_q, cell_y_q;
	logic [KIND_W-1:0]   cell_kind_q;
	logic [OPEN_W-1:0]   open_count_q;

	logic signed [SW-1:0] bx, by, cx, cy, lx, ly, nx, ny;
	logic signed [SW-1:0] rx, ry, wx, wy;
	logic [KIND_W-1:0]    wkind;
	logic                 g_we, g_re, rd_in, wr_in, push, border;
	logic [AW-1:0]        g_ra, g_wa;
	logic [KIND_W-1:0]    cell_val;
	logic [CNT_W:0]       div_t;
	logic [CNT_W-1:0]     ptr_plus;
	logic                 l_we, l_re;
	logic [LW-1:0]        l_wa, l_ra;
	logic [PW-1:0]        l_wd;
	logic [2:0]           k_next;

	function automatic logic in_grid(input logic signed [SW-1:0] x,
					 input logic signed [SW-1:0] y);
		in_grid = !x[SW-1] && !y[SW-1] && (x < SW'(GRID_W)) && (y < SW'(GRID_H));
	endfunction

	function automatic logic [AW-1:0] grid_addr(input logic signed [SW-1:0] x,
						    input logic signed [SW-1:0] y);
		grid_addr = AW'(32'(y[COORD_W-1:0]) * GRID_W + 32'(x[COORD_W-1:0]));
	endfunction

	// neighbour targets around the picked point
	always_comb begin
		bx = SW'($signed({2'b00, px_q}));
		by = SW'($signed({2'b00, py_q}));
		cx = bx + (SW'(step_dx(dir_q)) <<< 1);
		cy = by + (SW'(step_dy(dir_q)) <<< 1);
		lx = bx + SW'(step_dx(dir_q));
		ly = by + SW'(step_dy(dir_q));
		nx = bx + (SW'(step_dx(cmd.sel)) <<< 1);
		ny = by + (SW'(step_dy(cmd.sel)) <<< 1);
	end

	always_comb begin
		if (cmd.op == OP_CARVE_RD) begin
			rx = cx;
			ry = cy;
		end else begin
			rx = nx;
			ry = ny;
		end
		g_re  = (cmd.op == OP_CARVE_RD) || (cmd.op == OP_NB_FIRST) || (cmd.op == OP_NB);
		rd_in = in_grid(rx, ry);
		g_ra  = grid_addr(rx, ry);
	end

	assign border = (sx_q == '0) || (sy_q == '0) ||
			(sx_q == COORD_W'(GRID_W - 1)) || (sy_q == COORD_W'(GRID_H - 1));

	always_comb begin
		wx    = bx;
		wy    = by;
		wkind = KIND_PASSAGE;
		push  = 1'b0;
		case (cmd.op)
			OP_CLR: begin
				wx    = SW'($signed({2'b00, sx_q}));
				wy    = SW'($signed({2'b00, sy_q}));
				wkind = border ? KIND_PASSAGE : KIND_WALL;
			end
			OP_SEED: begin
				wx   = SW'($signed({4'b0000, start_x_q}));
				wy   = SW'($signed({4'b0000, start_y_q}));
				push = 1'b1;
			end
			OP_CARVE1: begin
				wx    = cx;
				wy    = cy;
				wkind = KIND_FRONTIER;
				push  = 1'b1;
			end
			OP_CARVE2: begin
				wx   = lx;
				wy   = ly;
				push = 1'b1;
			end
			OP_REMOVE: push = 1'b1;
			default: ;
		endcase
		wr_in = in_grid(wx, wy);
		g_wa  = grid_addr(wx, wy);
		g_we  = wr_in && (push || (cmd.op == OP_CLR));
	end

	always_ff @(posedge clk) begin
		if (g_we)
			grid_mem[g_wa] <= wkind;
		if (g_re) begin
			grid_rd_q <= grid_mem[g_ra];
			grid_in_q <= rd_in;
		end
	end

	// cells outside the grid read as passage
	assign cell_val = grid_in_q ? grid_rd_q : KIND_PASSAGE;

	assign ptr_plus = ptr_q + 1'b1;

	always_comb begin
		l_we = 1'b0;
		l_wa = '0;
		l_wd = list_rd_q;
		case (cmd.op)
			OP_SEED: begin
				l_we = 1'b1;
				l_wd = {2'b00, start_x_q, 2'b00, start_y_q};
			end
			OP_CARVE2: begin
				l_we = 1'b1;
				l_wa = count_q[LW-1:0];
				l_wd = {cx[COORD_W-1:0], cy[COORD_W-1:0]};
			end
			OP_SH_WR: begin
				l_we = 1'b1;
				l_wa = ptr_q[LW-1:0];
			end
			default: ;
		endcase
		l_re = (cmd.op == OP_PICK_RD) || (cmd.op == OP_SH_RD);
		l_ra = (cmd.op == OP_PICK_RD) ? rem_q[LW-1:0] : ptr_plus[LW-1:0];
	end

	always_ff @(posedge clk) begin
		if (l_we)
			list_mem[l_wa] <= l_wd;
		if (l_re)
			list_rd_q <= list_mem[l_ra];
	end

	assign div_t  = {rem_q, dvd_q[RAND_W-1]};
	assign k_next = {1'b0, k_q} + 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q   <= START_RESET;
			start_y_q   <= START_RESET;
			count_q     <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			div_cnt_q   <= '0;
			n_q         <= '0;
			k_q         <= '0;
			open_left_q <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_START_X)
					start_x_q <= cfg_data;
				if (cfg_index == REG_START_Y)
					start_y_q <= cfg_data;
			end
			strobe_q <= (cmd.op == OP_EMIT);
			if (push)
				n_q <= n_q + 1'b1;
			case (cmd.op)
				OP_LOAD: begin
					div_cnt_q <= '1;
					n_q       <= '0;
					k_q       <= '0;
				end
				OP_CLR: begin
					// sweep row by row, wrap back to the origin
					if (sx_q == COORD_W'(GRID_W - 1)) begin
						sx_q <= '0;
						sy_q <= (sy_q == COORD_W'(GRID_H - 1)) ? '0 : sy_q + 1'b1;
					end else begin
						sx_q <= sx_q + 1'b1;
					end
				end
				OP_SEED:     count_q <= CNT_W'(1);
				OP_DIV:      div_cnt_q <= div_cnt_q - 1'b1;
				OP_CARVE2:   count_q <= count_q + 1'b1;
				OP_NB_FIRST: open_left_q <= 1'b0;
				OP_NB, OP_NB_LAST:
					open_left_q <= open_left_q || (cell_val == KIND_WALL);
				OP_DEC:      count_q <= count_q - 1'b1;
				OP_EMIT:     k_q <= k_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				dvd_q       <= rand_value;
				rem_q       <= '0;
				dir_q       <= direction;
				slot_x_q[0] <= '0;
				slot_y_q[0] <= '0;
				slot_k_q[0] <= KIND_WALL;
			end
			OP_DIV: begin
				dvd_q <= dvd_q << 1;
				if (div_t >= {1'b0, count_q})
					rem_q <= CNT_W'(div_t - {1'b0, count_q});
				else
					rem_q <= div_t[CNT_W-1:0];
			end
			OP_PICK_LATCH: begin
				px_q <= list_rd_q[PW-1:COORD_W];
				py_q <= list_rd_q[COORD_W-1:0];
			end
			OP_REMOVE: ptr_q <= CNT_W'(rem_q[LW-1:0]);
			OP_SH_WR:  ptr_q <= ptr_plus;
			OP_EMIT: begin
				write_valid_q <= (k_q < n_q);
				cell_x_q      <= slot_x_q[k_q];
				cell_y_q      <= slot_y_q[k_q];
				cell_kind_q   <= slot_k_q[k_q];
				last_q        <= stat.emit_last;
				done_res_q    <= (count_q == '0);
				open_count_q  <= OPEN_W'(count_q);
			end
			default: ;
		endcase
		if (push) begin
			slot_x_q[n_q] <= wx[XY_OUT_W-1:0];
			slot_y_q[n_q] <= wy[XY_OUT_W-1:0];
			slot_k_q[n_q] <= wkind;
		end
	end

	always_comb begin
		stat.clr_last   = (sx_q == COORD_W'(GRID_W - 1)) && (sy_q == COORD_W'(GRID_H - 1));
		stat.div_last   = (div_cnt_q == '0);
		stat.count_zero = (count_q == '0);
		stat.carve_ok   = (cell_val == KIND_WALL) && (count_q < CNT_W'(LIST_DEPTH));
		stat.open_left  = open_left_q;
		stat.shift_more = (ptr_plus < count_q);
		stat.emit_last  = (k_next >= {1'b0, n_q});
	end

	assign strobe      = strobe_q;
	assign write_valid = write_valid_q;
	assign cell_x      = cell_x_q;
	assign cell_y      = cell_y_q;
	assign cell_kind   = cell_kind_q;
	assign last        = last_q;
	assign done_res    = done_res_q;
	assign open_count  = open_count_q;

	`GTM_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(LIST_DEPTH), "list count overflow")
	`GTM_ASSERT_IMP(a_write_kind, clk, arst_n, strobe_q && write_valid_q, cell_kind_q != KIND_WALL, "wall written as result")
	`GTM_ASSERT_NEXT(a_append, clk, arst_n, cmd.op == OP_CARVE2, count_q == $past(count_q) + 1'b1, "append lost")
	`GTM_ASSERT_NEXT(a_last_gap, clk, arst_n, strobe_q && last_q, !strobe_q, "result after last")

endmodule

// ----- rtl/gtm_ctrl.sv -----
module gtm_ctrl import gtm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      command,
	input  gtm_stat_t stat,
	output gtm_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_SEED,
		ST_DIV,
		ST_PICK,
		ST_PICKW,
		ST_CREAD,
		ST_CCHK,
		ST_CARVE1,
		ST_CARVE2,
		ST_NB0,
		ST_NB,
		ST_NBL,
		ST_RMCHK,
		ST_REMOVE,
		ST_SHCHK,
		ST_SHRD,
		ST_SHWR,
		ST_DEC,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic       restart_q;
	logic [1:0] nb_q;
	logic       busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			restart_q <= 1'b0;
			nb_q      <= '0;
			busy_q    <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						busy_q <= 1'b1;
						if (command == CMD_RESTART) begin
							restart_q <= 1'b1;
							state_q   <= ST_CLR;
						end else if (stat.count_zero) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_CLR: begin
					if (stat.clr_last) begin
						if (restart_q) begin
							state_q <= ST_SEED;
						end else begin
							state_q <= ST_IDLE;
							busy_q  <= 1'b0;
						end
					end
				end
				ST_SEED:   state_q <= ST_EMIT;
				ST_DIV:    if (stat.div_last) state_q <= ST_PICK;
				ST_PICK:   state_q <= ST_PICKW;
				ST_PICKW:  state_q <= ST_CREAD;
				ST_CREAD:  state_q <= ST_CCHK;
				ST_CCHK:   state_q <= stat.carve_ok ? ST_CARVE1 : ST_NB0;
				ST_CARVE1: state_q <= ST_CARVE2;
				ST_CARVE2: state_q <= ST_NB0;
				ST_NB0: begin
					nb_q    <= 2'd1;
					state_q <= ST_NB;
				end
				ST_NB: begin
					nb_q <= nb_q + 1'b1;
					if (nb_q == DIR_DOWN)
						state_q <= ST_NBL;
				end
				ST_NBL:    state_q <= ST_RMCHK;
				ST_RMCHK:  state_q <= stat.open_left ? ST_EMIT : ST_REMOVE;
				ST_REMOVE: state_q <= ST_SHCHK;
				ST_SHCHK:  state_q <= stat.shift_more ? ST_SHRD : ST_DEC;
				ST_SHRD:   state_q <= ST_SHWR;
				ST_SHWR:   state_q <= ST_SHCHK;
				ST_DEC:    state_q <= ST_EMIT;
				ST_EMIT: begin
					if (stat.emit_last) begin
						state_q   <= ST_IDLE;
						restart_q <= 1'b0;
						busy_q    <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.sel = 2'd0;
		case (state_q)
			ST_IDLE:   cmd.op = start ? OP_LOAD : OP_NONE;
			ST_CLR:    cmd.op = OP_CLR;
			ST_SEED:   cmd.op = OP_SEED;
			ST_DIV:    cmd.op = OP_DIV;
			ST_PICK:   cmd.op = OP_PICK_RD;
			ST_PICKW:  cmd.op = OP_PICK_LATCH;
			ST_CREAD:  cmd.op = OP_CARVE_RD;
			ST_CARVE1: cmd.op = OP_CARVE1;
			ST_CARVE2: cmd.op = OP_CARVE2;
			ST_NB0:    cmd.op = OP_NB_FIRST;
			ST_NB: begin
				cmd.op  = OP_NB;
				cmd.sel = nb_q;
			end
			ST_NBL:    cmd.op = OP_NB_LAST;
			ST_REMOVE: cmd.op = OP_REMOVE;
			ST_SHRD:   cmd.op = OP_SH_RD;
			ST_SHWR:   cmd.op = OP_SH_WR;
			ST_DEC:    cmd.op = OP_DEC;
			ST_EMIT:   cmd.op = OP_EMIT;
			default:   cmd.op = OP_NONE;
		endcase
	end

	assign busy = busy_q;

endmodule
